// ----- sv/pulse_period_rate_meter_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the pulse period rate meter
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PULSE_PERIOD_RATE_METER_ASSERT_SVH
`define PULSE_PERIOD_RATE_METER_ASSERT_SVH

// Same-cycle implication
`define PPRM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pprm assertion failed");

// Next-cycle implication
`define PPRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pprm assertion failed");

`endif

// ----- sv/pprm_pkg.sv -----
// ----------------------------------------------------------------------------
// pprm_pkg
// Types, sizes and register codes of the pulse period rate meter.
// ----------------------------------------------------------------------------
package pprm_pkg;

  // Window depth and timestamp width
  localparam int MAX_WINDOW = 8;
  localparam int TIME_BITS  = 48;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int REG_W      = 32;
  localparam int DCNT_W     = $clog2(TIME_BITS + 1);

  // Configuration register indexes
  localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [1:0] REG_WATCHDOG    = 2'd1;
  localparam logic [1:0] REG_CADENCE     = 2'd2;
  localparam logic [1:0] REG_SPEED       = 2'd3;

  // Reset values
  localparam logic [CNT_W-1:0] WINDOW_RST   = CNT_W'(3);
  localparam logic [CNT_W-1:0] WINDOW_MIN   = CNT_W'(2);
  localparam logic [REG_W-1:0] WATCHDOG_RST = 32'd4000000;
  localparam logic [REG_W-1:0] CADENCE_RST  = 32'd60000000;
  localparam logic [REG_W-1:0] SPEED_RST    = 32'd1800000000;
  localparam logic [REG_W-1:0] MEAN_MAX     = 32'hFFFF_FFFF;

  // Operation codes
  localparam logic OP_PULSE  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [TIME_BITS-1:0] time_us;
  } in_beat_t;

  typedef struct packed {
    logic             active;
    logic [REG_W-1:0] mean_interval;
    logic [REG_W-1:0] cadence;
    logic [REG_W-1:0] speed_x100;
  } out_beat_t;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_CHK      = 7'b0000010,
    ST_LOAD     = 7'b0000100,
    ST_DIV_MEAN = 7'b0001000,
    ST_DIV_CAD  = 7'b0010000,
    ST_DIV_SPD  = 7'b0100000,
    ST_EMIT     = 7'b1000000
  } state_t;

  // Ring slot at offset from head, modulo the window depth
  function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(MAX_WINDOW)) begin
      sum = sum - (CNT_W+1)'(MAX_WINDOW);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ----- sv/pulse_period_rate_meter.sv -----
// ----------------------------------------------------------------------------
// pulse_period_rate_meter
// Period-averaging tachometer: keeps recent pulse timestamps and reports the
// mean interval and two rates from one shared bit-serial divider.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    in_beat_t  (op, time_us)
//  out      output     out_valid/out_ready  out_beat_t (active, mean, rates)
//  cfg      input      cfg_we               cfg_addr, cfg_wdata
//
//  A pulse beat is stored straight from idle. An update with fewer than two
//  stamps, or with a newest stamp older than the watchdog, skips the divider;
//  an active update has the radix-2 divider run mean, cadence, speed in turn.
//  Reset is synchronous; the stamp memory is not cleared and needs no sweep.
//  A held result stalls the emit step, with in_ready low; new beats are taken
//  while the result waits in the output register and the sequencer is idle.
// ----------------------------------------------------------------------------
module pulse_period_rate_meter
  import pprm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_beat_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [REG_W-1:0] cfg_wdata
);

  // Configuration
  logic [CNT_W-1:0] win_r, win_nxt;
  logic [REG_W-1:0] wdt_r, wdt_nxt;
  logic [REG_W-1:0] cad_k_r, cad_k_nxt;
  logic [REG_W-1:0] spd_k_r, spd_k_nxt;

  // Window control
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Stamp memory
  logic [TIME_BITS-1:0] ring_mem [MAX_WINDOW];
  logic [TIME_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic                 wr_en;

  // Sequencer and working values
  state_t               state_r, state_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [TIME_BITS-1:0] newest_r, newest_nxt;

  // Shared divider
  logic [TIME_BITS-1:0] div_q_r, div_q_nxt;
  logic [REG_W-1:0]     div_rem_r, div_rem_nxt;
  logic [REG_W-1:0]     div_d_r, div_d_nxt;
  logic [DCNT_W-1:0]    div_cnt_r, div_cnt_nxt;
  logic [REG_W:0]       div_shift;
  logic [REG_W:0]       div_diff;
  logic                 div_ge;
  logic [REG_W-1:0]     step_rem;
  logic [TIME_BITS-1:0] step_q;
  logic                 div_last;

  // Result holding and output register
  logic             res_active_r, res_active_nxt;
  logic [REG_W-1:0] res_mean_r, res_mean_nxt;
  logic [REG_W-1:0] res_cad_r, res_cad_nxt;
  logic [REG_W-1:0] res_spd_r, res_spd_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_data_r, out_data_nxt;

  // Misc
  logic             in_fire;
  logic [TIME_BITS-1:0] age;
  logic [CNT_W-1:0] newest_off;
  logic [CNT_W-1:0] win_wr;
  logic [REG_W-1:0] mean_sat;
  logic             out_rates_zero;
  logic             out_all_zero;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Clamp the window size field to 2..MAX_WINDOW
  always_comb begin
    if (cfg_wdata[3:0] < 4'd2) begin
      win_wr = WINDOW_MIN;
    end else if (8'(cfg_wdata[3:0]) > 8'(MAX_WINDOW)) begin
      win_wr = CNT_W'(MAX_WINDOW);
    end else begin
      win_wr = CNT_W'(cfg_wdata[3:0]);
    end
  end

  // One restoring divider step
  assign div_shift = {div_rem_r, div_q_r[TIME_BITS-1]};
  assign div_diff  = div_shift - {1'b0, div_d_r};
  assign div_ge    = (div_shift >= {1'b0, div_d_r});
  assign step_rem  = div_ge ? div_diff[REG_W-1:0] : div_shift[REG_W-1:0];
  assign step_q    = {div_q_r[TIME_BITS-2:0], div_ge};
  assign div_last  = (div_cnt_r == DCNT_W'(1));

  // Saturate the mean to 32 bits
  assign mean_sat = (step_q > TIME_BITS'(MEAN_MAX)) ? MEAN_MAX : step_q[REG_W-1:0];

  assign newest_off = (count_r == '0) ? '0 : count_r - CNT_W'(1);
  assign age        = now_r - rd_data_r;

  // Sequencer
  always_comb begin
    win_nxt        = win_r;
    wdt_nxt        = wdt_r;
    cad_k_nxt      = cad_k_r;
    spd_k_nxt      = spd_k_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    state_nxt      = state_r;
    now_nxt        = now_r;
    newest_nxt     = newest_r;
    div_q_nxt      = div_q_r;
    div_rem_nxt    = div_rem_r;
    div_d_nxt      = div_d_r;
    div_cnt_nxt    = div_cnt_r;
    res_active_nxt = res_active_r;
    res_mean_nxt   = res_mean_r;
    res_cad_nxt    = res_cad_r;
    res_spd_nxt    = res_spd_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    rd_addr        = ring_slot(head_r, newest_off);
    wr_addr        = ring_slot(head_r, count_r);
    wr_en          = 1'b0;

    // Drop the output beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Register writes
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_WINDOW_SIZE: begin
          win_nxt   = win_wr;
          head_nxt  = '0;
          count_nxt = '0;
        end
        REG_WATCHDOG: wdt_nxt   = cfg_wdata;
        REG_CADENCE:  cad_k_nxt = cfg_wdata;
        REG_SPEED:    spd_k_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          now_nxt = in_data.time_us;
          if (in_data.op == OP_PULSE) begin
            // Append, or overwrite past the newest and advance past the oldest
            wr_en = 1'b1;
            if (count_r < win_r) begin
              count_nxt = count_r + CNT_W'(1);
            end else begin
              wr_addr   = ring_slot(head_r, win_r);
              head_nxt  = ring_slot(head_r, CNT_W'(1));
              count_nxt = win_r;
            end
          end else begin
            state_nxt = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        // rd_data_r holds the newest stamp; fetch the oldest next
        rd_addr    = head_r;
        newest_nxt = rd_data_r;
        if (count_r != '0 && age > TIME_BITS'(wdt_r)) begin
          head_nxt  = '0;
          count_nxt = '0;
          rd_addr   = '0;
        end
        if (count_r < CNT_W'(2) || (age > TIME_BITS'(wdt_r))) begin
          res_active_nxt = 1'b0;
          res_mean_nxt   = '0;
          res_cad_nxt    = '0;
          res_spd_nxt    = '0;
          state_nxt      = ST_EMIT;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        div_q_nxt   = newest_r - rd_data_r;
        div_d_nxt   = REG_W'(count_r - CNT_W'(1));
        div_rem_nxt = '0;
        div_cnt_nxt = DCNT_W'(TIME_BITS);
        state_nxt   = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: begin
        div_q_nxt   = step_q;
        div_rem_nxt = step_rem;
        div_cnt_nxt = div_cnt_r - DCNT_W'(1);
        if (div_last) begin
          res_active_nxt = 1'b1;
          res_mean_nxt   = mean_sat;
          if (mean_sat == '0) begin
            res_cad_nxt = '0;
            res_spd_nxt = '0;
            state_nxt   = ST_EMIT;
          end else begin
            div_q_nxt   = TIME_BITS'(cad_k_r) << (TIME_BITS - REG_W);
            div_d_nxt   = mean_sat;
            div_rem_nxt = '0;
            div_cnt_nxt = DCNT_W'(REG_W);
            state_nxt   = ST_DIV_CAD;
          end
        end
      end
      ST_DIV_CAD: begin
        div_q_nxt   = step_q;
        div_rem_nxt = step_rem;
        div_cnt_nxt = div_cnt_r - DCNT_W'(1);
        if (div_last) begin
          res_cad_nxt = step_q[REG_W-1:0];
          div_q_nxt   = TIME_BITS'(spd_k_r) << (TIME_BITS - REG_W);
          div_rem_nxt = '0;
          div_cnt_nxt = DCNT_W'(REG_W);
          state_nxt   = ST_DIV_SPD;
        end
      end
      ST_DIV_SPD: begin
        div_q_nxt   = step_q;
        div_rem_nxt = step_rem;
        div_cnt_nxt = div_cnt_r - DCNT_W'(1);
        if (div_last) begin
          res_spd_nxt = step_q[REG_W-1:0];
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Load the output beat once the register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.active        = res_active_r;
          out_data_nxt.mean_interval = res_mean_r;
          out_data_nxt.cadence       = res_cad_r;
          out_data_nxt.speed_x100    = res_spd_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Stamp memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= now_nxt;
    end
    rd_data_r <= ring_mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WINDOW_RST;
      wdt_r       <= WATCHDOG_RST;
      cad_k_r     <= CADENCE_RST;
      spd_k_r     <= SPEED_RST;
      head_r      <= '0;
      count_r     <= '0;
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      wdt_r       <= wdt_nxt;
      cad_k_r     <= cad_k_nxt;
      spd_k_r     <= spd_k_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    now_r        <= now_nxt;
    newest_r     <= newest_nxt;
    div_q_r      <= div_q_nxt;
    div_rem_r    <= div_rem_nxt;
    div_d_r      <= div_d_nxt;
    div_cnt_r    <= div_cnt_nxt;
    res_active_r <= res_active_nxt;
    res_mean_r   <= res_mean_nxt;
    res_cad_r    <= res_cad_nxt;
    res_spd_r    <= res_spd_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Checks
  assign out_rates_zero = (out_data_r.cadence == '0) && (out_data_r.speed_x100 == '0);
  assign out_all_zero   = out_rates_zero && (out_data_r.mean_interval == '0);

`include "pulse_period_rate_meter_assert.svh"

  `PPRM_ASSERT_IMPL(a_count_in_window, 1'b1, count_r <= win_r)
  `PPRM_ASSERT_NEXT(a_update_checks, in_fire && in_data.op == OP_UPDATE, state_r == ST_CHK)
  `PPRM_ASSERT_IMPL(a_idle_zero, out_valid_r && !out_data_r.active, out_all_zero)
  `PPRM_ASSERT_IMPL(a_zero_mean_rates, out_valid_r && out_data_r.mean_interval == '0, out_rates_zero)

endmodule
